// ===== src/ppc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

  // byte lanes carried on the bus, and lanes that take part in decoding
  localparam int KEY_MAX   = 16;
  localparam int KEY_BYTES = 16;
  localparam int SEG_W     = 16;
  localparam int LVL_W     = 5;

  typedef struct packed {
    logic [KEY_MAX-1:0]   starts;
    logic [8*KEY_MAX-1:0] bytes;
  } key_t;

  typedef logic [KEY_BYTES-1:0][SEG_W-1:0] seg_list_t;

  localparam logic [1:0] ORDER_BEFORE = 2'b11;
  localparam logic [1:0] ORDER_EQUAL  = 2'b00;
  localparam logic [1:0] ORDER_AFTER  = 2'b01;

endpackage

`default_nettype wire

// ===== src/ppc_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ppc_decode
  import ppc_pkg::*;
(
  input  key_t             key,
  output seg_list_t        segs,
  output logic [LVL_W-1:0] levels
);

  logic [KEY_BYTES:0]                mark_ext;
  logic [KEY_BYTES:0][7:0]           bval;
  logic [KEY_BYTES-1:0]              term;
  logic [KEY_BYTES-1:0]              seg_start;
  logic [KEY_BYTES-1:0][SEG_W-1:0]   val;
  logic [KEY_BYTES-1:0][LVL_W-1:0]   idx;

  // every marked byte ahead of the first marked zero opens a segment;
  // skipped bytes are always unmarked, so no sequential scan is needed
  always_comb begin
    mark_ext = {1'b1, key.starts[KEY_BYTES-1:0]};
    bval[KEY_BYTES] = 8'h00;
    for (int p = 0; p < KEY_BYTES; p++) begin
      bval[p] = key.bytes[8*p +: 8];
      term[p] = mark_ext[p] && (bval[p] == 8'h00);
    end
    for (int p = 0; p < KEY_BYTES; p++) begin
      logic ended;
      logic [KEY_BYTES-1:0] below;
      ended = 1'b0;
      below = '0;
      for (int q = 0; q < KEY_BYTES; q++) begin
        if (q < p) begin
          ended    = ended | term[q];
          below[q] = 1'b1;
        end
      end
      seg_start[p] = mark_ext[p] && !term[p] && !ended;
      if (!mark_ext[p+1]) begin
        val[p] = {bval[p], bval[p+1]};
      end else begin
        val[p] = {8'h00, bval[p]};
      end
      idx[p] = LVL_W'($countones(seg_start & below));
    end
  end

  // compact segments into list order
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      segs[i] = '0;
      for (int p = 0; p < KEY_BYTES; p++) begin
        if (seg_start[p] && (idx[p] == LVL_W'(i))) begin
          segs[i] = segs[i] | val[p];
        end
      end
    end
    levels = LVL_W'($countones(seg_start));
  end

endmodule

`default_nettype wire

// ===== src/packed_path_compare.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  width  fields (lowest bit up)
// s_*      in   288    a_bytes_low, a_bytes_high, a_starts, b_bytes_low, b_bytes_high, b_starts
// m_*      out  16     order, a_under_b, b_under_a, a_levels, b_levels, 2 zero bits
//
// Three register stages: input, decoded segment lists, result. One transaction
// per cycle sustained while m_tready stays high.
// rst clears the stage valid bits only.
// A stalled result holds all stages; s_tready follows from the output stage.

module packed_path_compare
  import ppc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [287:0] s_tdata,   // a_bytes_low, a_bytes_high, a_starts,
                                       // b_bytes_low, b_bytes_high, b_starts
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [15:0]       m_tdata    // order, a_under_b, b_under_a,
                                       // a_levels, b_levels, zero pad
);

  logic             en;
  logic             in_valid;
  key_t             key_a;
  key_t             key_b;

  seg_list_t        segs_a_dec;
  seg_list_t        segs_b_dec;
  logic [LVL_W-1:0] lvl_a_dec;
  logic [LVL_W-1:0] lvl_b_dec;

  logic             dec_valid;
  seg_list_t        segs_a;
  seg_list_t        segs_b;
  logic [LVL_W-1:0] lvl_a;
  logic [LVL_W-1:0] lvl_b;

  logic [KEY_BYTES-1:0] diff;
  logic [KEY_BYTES-1:0] less;
  logic [KEY_BYTES-1:0] first;
  logic [1:0]           order_next;
  logic                 a_under_b_next;
  logic                 b_under_a_next;

  logic             out_valid;
  logic [1:0]       order;
  logic             a_under_b;
  logic             b_under_a;
  logic [LVL_W-1:0] a_levels;
  logic [LVL_W-1:0] b_levels;

  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      dec_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      in_valid  <= s_tvalid;
      dec_valid <= in_valid;
      out_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_a     <= '{starts: s_tdata[143:128], bytes: s_tdata[127:0]};
      key_b     <= '{starts: s_tdata[287:272], bytes: s_tdata[271:144]};
      segs_a    <= segs_a_dec;
      segs_b    <= segs_b_dec;
      lvl_a     <= lvl_a_dec;
      lvl_b     <= lvl_b_dec;
      order     <= order_next;
      a_under_b <= a_under_b_next;
      b_under_a <= b_under_a_next;
      a_levels  <= lvl_a;
      b_levels  <= lvl_b;
    end
  end

  ppc_decode u_dec_a (
    .key    (key_a),
    .segs   (segs_a_dec),
    .levels (lvl_a_dec)
  );

  ppc_decode u_dec_b (
    .key    (key_b),
    .segs   (segs_b_dec),
    .levels (lvl_b_dec)
  );

  // first differing segment within the common length decides; with none, the shorter list orders first
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      diff[i] = (LVL_W'(i) < lvl_a) && (LVL_W'(i) < lvl_b) && (segs_a[i] != segs_b[i]);
      less[i] = segs_a[i] < segs_b[i];
    end
    first = diff & (~diff + KEY_BYTES'(1));
    if (|diff) begin
      order_next = (|(first & less)) ? ORDER_BEFORE : ORDER_AFTER;
    end else if (lvl_a < lvl_b) begin
      order_next = ORDER_BEFORE;
    end else if (lvl_a > lvl_b) begin
      order_next = ORDER_AFTER;
    end else begin
      order_next = ORDER_EQUAL;
    end
    a_under_b_next = !(|diff) && (lvl_b <= lvl_a);
    b_under_a_next = !(|diff) && (lvl_a <= lvl_b);
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, b_levels, a_levels, b_under_a, a_under_b, order};

`ifndef ASSERT_OFF
  a_equal_both_under: assert property (@(posedge clk) disable iff (rst)
    out_valid && (order == ORDER_EQUAL) |-> a_under_b && b_under_a)
    else $error("equal keys not mutual prefixes");

  a_mutual_same_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && a_under_b && b_under_a |-> (a_levels == b_levels))
    else $error("mutual prefixes with different lengths");

  a_under_longer: assert property (@(posedge clk) disable iff (rst)
    out_valid && a_under_b && !b_under_a |-> (order == ORDER_AFTER))
    else $error("descendant not ordered after ancestor");

  a_levels_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (a_levels <= LVL_W'(KEY_BYTES)) && (b_levels <= LVL_W'(KEY_BYTES)))
    else $error("segment count out of range");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    en && dec_valid |=> out_valid)
    else $error("decoded item lost");
`endif

endmodule

`default_nettype wire

// ===== verif/packed_path_compare_test.sv =====
`timescale 1ns / 1ps

module packed_path_compare_test;
  import ppc_pkg::*;

  localparam int unsigned LIMIT = 100000;

  // result fields, lowest bit last
  typedef struct packed {
    logic [1:0]       pad;
    logic [LVL_W-1:0] b_levels;
    logic [LVL_W-1:0] a_levels;
    logic             b_under_a;
    logic             a_under_b;
    logic [1:0]       order;
  } verdict_t;

  typedef struct {
    logic [KEY_BYTES-1:0][SEG_W-1:0] val;
    logic [KEY_BYTES-1:0]            wide;
    int unsigned                     n;
  } path_t;

  typedef enum {SAME_PATH, CUT_PATH, LONGER_PATH, ALTERED_PATH, OTHER_PATH} relation_e;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;  // a_bytes_low, a_bytes_high, a_starts,
                               // b_bytes_low, b_bytes_high, b_starts
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;       // order, a_under_b, b_under_a, a_levels, b_levels, pad

  verdict_t    expected_verdicts[$];
  int unsigned issued = 0;
  int unsigned checked = 0;
  int unsigned mismatches = 0;
  int unsigned n_before = 0, n_equal = 0, n_after = 0, n_ancestor = 0;
  int unsigned cycles = 0;
  int unsigned hold = 0;
  bit          calm = 1'b0;

  packed_path_compare uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("packed_path_compare_test NOT OK");
      $finish;
    end
  end

  function automatic void split_key(input key_t k, output seg_list_t segs,
                                    output int unsigned count);
    int unsigned pos;
    bit          done;
    segs = '0;
    count = 0;
    pos = 0;
    done = 1'b0;
    while (pos < KEY_BYTES && !done) begin
      if (!k.starts[pos]) begin
        pos++;
      end else if (k.bytes[8*pos +: 8] == 8'h00) begin
        done = 1'b1;
      end else if (pos + 1 < KEY_BYTES && !k.starts[pos+1]) begin
        segs[count] = {k.bytes[8*pos +: 8], k.bytes[8*(pos+1) +: 8]};
        count++;
        pos += 2;
      end else begin
        segs[count] = {8'h00, k.bytes[8*pos +: 8]};
        count++;
        pos++;
      end
    end
  endfunction

  function automatic verdict_t rank_keys(key_t a, key_t b);
    seg_list_t   sa, sb;
    int unsigned na, nb, i, common;
    bit          split;
    verdict_t    v;
    split_key(a, sa, na);
    split_key(b, sb, nb);
    v = '0;
    split = 1'b0;
    common = (na < nb) ? na : nb;
    for (i = 0; i < common && !split; i++) begin
      if (sa[i] != sb[i]) begin
        split = 1'b1;
        v.order = (sa[i] < sb[i]) ? ORDER_BEFORE : ORDER_AFTER;
      end
    end
    if (!split) begin
      v.order = (na < nb) ? ORDER_BEFORE : (na > nb) ? ORDER_AFTER : ORDER_EQUAL;
      v.a_under_b = (nb <= na);
      v.b_under_a = (na <= nb);
    end
    v.a_levels = LVL_W'(na);
    v.b_levels = LVL_W'(nb);
    return v;
  endfunction

  always @(posedge clk) begin : scoreboard
    verdict_t got, want;
    if (!rst && s_tvalid && s_tready)
      expected_verdicts.push_back(rank_keys(key_t'(s_tdata[143:0]), key_t'(s_tdata[287:144])));
    if (!rst && m_tvalid && m_tready) begin
      got = verdict_t'(m_tdata);
      checked++;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction %h", m_tdata);
      end else begin
        want = expected_verdicts.pop_front();
        case (want.order)
          ORDER_BEFORE: n_before++;
          ORDER_AFTER:  n_after++;
          default:      n_equal++;
        endcase
        if (want.a_under_b != want.b_under_a)
          n_ancestor++;
        if (got.order !== want.order || got.a_under_b !== want.a_under_b ||
            got.b_under_a !== want.b_under_a || got.a_levels !== want.a_levels ||
            got.b_levels !== want.b_levels) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp order %b a<b %b b<a %b lv %0d/%0d, got %b %b %b %0d/%0d",
                     checked, want.order, want.a_under_b, want.b_under_a, want.a_levels,
                     want.b_levels, got.order, got.a_under_b, got.b_under_a,
                     got.a_levels, got.b_levels);
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else if (hold > 0) begin
      hold = hold - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      hold = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_pair(input key_t a, input key_t b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, a};
    do @(posedge clk); while (!s_tready);
    issued++;
  endtask

  function automatic logic [SEG_W-1:0] fresh_segment(bit wide);
    logic [7:0] hi;
    hi = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 3)) : 8'($urandom_range(1, 255));
    return wide ? {hi, 8'($urandom)} : {8'h00, hi};
  endfunction

  function automatic path_t grow_path(path_t p, int unsigned target);
    int unsigned room, i;
    room = KEY_BYTES;
    for (i = 0; i < p.n; i++)
      room -= p.wide[i] ? 2 : 1;
    while (p.n < target && room > 0) begin
      p.wide[p.n] = (room > 1) && ($urandom_range(0, 1) == 1);
      p.val[p.n] = fresh_segment(p.wide[p.n]);
      room -= p.wide[p.n] ? 2 : 1;
      p.n++;
    end
    return p;
  endfunction

  function automatic int unsigned path_depth();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
  endfunction

  // well-formed key: optional skipped bytes, segments, terminator if there is room, then junk
  function automatic key_t encode_path(path_t p);
    key_t        k;
    int unsigned pos, i, used;
    k = '0;
    used = 0;
    for (i = 0; i < p.n; i++)
      used += p.wide[i] ? 2 : 1;
    pos = 0;
    if (used + 2 <= KEY_BYTES && $urandom_range(0, 3) == 0)
      pos = $urandom_range(1, 2);
    for (i = 0; i < pos; i++)
      k.bytes[8*i +: 8] = 8'($urandom);
    for (i = 0; i < p.n; i++) begin
      k.starts[pos] = 1'b1;
      if (p.wide[i]) begin
        k.bytes[8*pos +: 16] = {p.val[i][7:0], p.val[i][15:8]};
        pos += 2;
      end else begin
        k.bytes[8*pos +: 8] = p.val[i][7:0];
        pos++;
      end
    end
    if (pos < KEY_BYTES) begin
      k.starts[pos] = 1'b1;
      for (i = pos + 1; i < KEY_BYTES; i++) begin
        k.bytes[8*i +: 8] = 8'($urandom);
        k.starts[i] = $urandom_range(0, 1);
      end
    end
    return k;
  endfunction

  function automatic key_t noise_key();
    key_t k;
    k.bytes = {$urandom, $urandom, $urandom, $urandom};
    k.starts = 16'($urandom);
    return k;
  endfunction

  task automatic random_pair();
    path_t       pa, pb;
    key_t        ka, kb;
    int unsigned i;
    if ($urandom_range(0, 9) >= 8) begin
      ka = noise_key();
      kb = ($urandom_range(0, 3) == 0) ? ka : noise_key();
    end else begin
      pa.n = 0;
      pa = grow_path(pa, path_depth());
      pb = pa;
      case (relation_e'($urandom_range(0, 4)))
        SAME_PATH: ;
        CUT_PATH: pb.n = $urandom_range(0, pb.n);
        LONGER_PATH: pb = grow_path(pb, pb.n + $urandom_range(1, 4));
        ALTERED_PATH: begin
          if (pb.n > 0) begin
            i = $urandom_range(0, pb.n - 1);
            pb.val[i] = fresh_segment(pb.wide[i]);
          end
        end
        default: begin
          pb.n = 0;
          pb = grow_path(pb, path_depth());
        end
      endcase
      ka = encode_path(pa);
      kb = encode_path(pb);
    end
    if ($urandom_range(0, 1) == 1)
      send_pair(ka, kb);
    else
      send_pair(kb, ka);
  endtask

  task automatic test_extremes();
    send_pair({16'h0000, 128'h0}, {16'h0000, 128'h0});
    send_pair({16'hFFFF, {16{8'hFF}}}, {16'h0000, {16{8'hFF}}});
    send_pair({16'h5555, {16{8'hFF}}}, {16'hFFFF, {16{8'hFF}}});
    send_pair({16'hFFFF, 128'h0}, {16'h0001, {16{8'hA5}}});
    send_pair({16'hFFFF, {16{8'h01}}}, {16'hFFFF, {16{8'h01}}});
  endtask

  task automatic test_special_cases();
    // skipped leading bytes
    send_pair({16'h000C, 128'h0302_BBAA}, {16'h0003, 128'h0302});
    // marked last byte vs two-byte segment ending there
    send_pair({16'h8000, {8'h7E, 120'h0}}, {16'h4000, {8'h00, 8'h7E, 112'h0}});
    // no terminator
    send_pair({16'hAAAA, {16{8'h11}}}, {16'hAAAA, {8'h12, {15{8'h11}}}});
    // marked zero ends the path; unmarked zero is a low byte
    send_pair({16'h0003, 128'h0001}, {16'h0001, 128'h0001});
    send_pair({16'h0005, 128'h05_0001}, {16'h0001, 128'h0001});
    send_pair({16'h0000, 128'h0}, {16'h0001, 128'h2A});
    send_pair({16'h0001, 128'h2A}, {16'h0000, 128'h0});
  endtask

  task automatic test_ordering();
    send_pair({16'h0003, 128'h0201}, {16'h0007, 128'h030201});
    send_pair({16'h0007, 128'h030201}, {16'h0003, 128'h0201});
    send_pair({16'h0003, 128'h0501}, {16'h0003, 128'h0301});
    send_pair({16'h0001, 128'hFF}, {16'h0001, 128'h0101});
    send_pair({16'h0001, 128'h0001}, {16'h0001, 128'hFFFF});
    send_pair({16'hFFFF, 128'h100F0E0D0C0B0A090807060504030201},
              {16'hFFFF, 128'h100F0E0D0C0B0A090807060504030201});
    send_pair({16'hFFFF, 128'h100F0E0D0C0B0A090807060504030201},
              {16'hFFFF, 128'h110F0E0D0C0B0A090807060504030201});
  endtask

  task automatic test_drain_pause();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (checked < issued);
  endtask

  task automatic test_random_paths(int unsigned count);
    repeat (count) random_pair();
  endtask

  task automatic test_full_rate(int unsigned count);
    calm = 1'b1;
    repeat (count) random_pair();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_special_cases();
    test_ordering();
    test_drain_pause();
    test_random_paths(200);
    test_drain_pause();
    test_random_paths(180);
    test_full_rate(150);
    s_tvalid <= 1'b0;
    while (checked < issued) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d key pairs compared: %0d ordered before, %0d equal, %0d after",
             checked, n_before, n_equal, n_after);
    $display("%0d pairs had one key a strict ancestor of the other; %0d mismatches",
             n_ancestor, mismatches);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("packed_path_compare_test OK");
    end else begin
      $display("packed_path_compare_test NOT OK");
    end
    $finish;
  end

endmodule
